FILE: rtl/spmd_pkg.sv
// ----------------------------------------------------------------------------
// spmd_pkg
// Shared types and constants for the shortest-path matrix block.
// ----------------------------------------------------------------------------
package spmd_pkg;

  localparam int NODES_DEF       = 8;
  localparam int WEIGHT_BITS_DEF = 8;

  localparam int NODE_FIELD_BITS = 3;
  localparam int WEIGHT_FIELD    = 8;
  localparam int WEIGHT_MAX_BITS = 16;

  localparam int S_DATA_BITS = 24;
  localparam int M_DATA_BITS = 16;

  localparam int DIST_BITS = 12;
  localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};
  localparam logic [DIST_BITS:0]   KEY_NONE = {1'b1, {DIST_BITS{1'b0}}};

  localparam int ROUTE_MAX  = 8;
  localparam int ROUTE_BITS = 3;
  localparam int LEN_BITS   = 4;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INIT,
    ST_SEL,
    ST_MARK,
    ST_RELAX,
    ST_WALK_RD,
    ST_WALK,
    ST_EMIT
  } spmd_state_t;

endpackage

FILE: rtl/shortest_path_matrix_dijkstra.sv
// ----------------------------------------------------------------------------
// shortest_path_matrix_dijkstra
// Adjacency-matrix shortest route search with a sequenced scan unit.
// ----------------------------------------------------------------------------
// Input stream (s_axis): tuser selects the transaction kind. A write sets one
// edge weight of the matrix (weight zero removes the edge) and returns nothing.
// A query names start and goal nodes and returns the route one node per
// output transaction, start first, with tlast on the goal node. Every output
// carries the total distance (saturated at 4095) and a reachable flag; an
// unreachable goal gives a single transaction holding the start node.
// Search: a write leaves the input open. A query scans the node-state memory,
// one node a cycle, twice per round (select, then relax), over NODES-1
// rounds; a round whose chosen node was never reached skips the relax scan.
// s_axis_tready is low while a query runs.
// Output: a single output register; a stalled receiver freezes the route
// emission and holds the block busy until the last node is loaded into it.
// Reset: after rst the edge matrix is swept to zero, one entry a cycle, over
// all NODES*NODES entries, with s_axis_tready low.
// ----------------------------------------------------------------------------
module shortest_path_matrix_dijkstra #(
  parameter int NODES       = spmd_pkg::NODES_DEF,
  parameter int WEIGHT_BITS = spmd_pkg::WEIGHT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // edge_from, edge_to, edge_weight, start_node, goal_node, zero pad
  input  logic [spmd_pkg::S_DATA_BITS-1:0] s_axis_tdata,
  // func
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // path_node, route_distance, reachable
  output logic [spmd_pkg::M_DATA_BITS-1:0] m_axis_tdata,
  output logic                             m_axis_tlast
);

  import spmd_pkg::*;

  localparam int NW = $clog2(NODES);
  localparam int CW = $clog2(NODES + 1);
  localparam int EDGES = NODES * NODES;
  localparam int AW = $clog2(EDGES);
  localparam int SW = ((WEIGHT_BITS > DIST_BITS) ? WEIGHT_BITS : DIST_BITS) + 1;

  typedef struct packed {
    logic                 done;
    logic                 reached;
    logic [NW-1:0]        parent;
    logic [DIST_BITS-1:0] distance;
  } node_t;

  // input fields
  logic [NODE_FIELD_BITS-1:0] f_from, f_to, f_start, f_goal;
  logic [WEIGHT_FIELD-1:0]    f_weight;
  logic [WEIGHT_MAX_BITS-1:0] weight_ext;
  logic [7:0]                 start_ext, goal_ext;

  assign f_from     = s_axis_tdata[2:0];
  assign f_to       = s_axis_tdata[5:3];
  assign f_weight   = s_axis_tdata[13:6];
  assign f_start    = s_axis_tdata[16:14];
  assign f_goal     = s_axis_tdata[19:17];
  assign weight_ext = {{(WEIGHT_MAX_BITS-WEIGHT_FIELD){1'b0}}, f_weight};
  assign start_ext  = {5'd0, f_start};
  assign goal_ext   = {5'd0, f_goal};

  // memories
  logic [WEIGHT_BITS-1:0] edge_mem [EDGES];
  node_t                  node_mem [NODES];

  logic                   e_we;
  logic [AW-1:0]          e_waddr, e_raddr;
  logic [WEIGHT_BITS-1:0] e_wdata, e_rdata;
  logic                   n_we;
  logic [NW-1:0]          n_waddr, n_raddr;
  node_t                  n_wdata, n_rdata;

  always_ff @(posedge clk) begin
    if (e_we) begin
      edge_mem[e_waddr] <= e_wdata;
    end
    e_rdata <= edge_mem[e_raddr];
  end

  always_ff @(posedge clk) begin
    if (n_we) begin
      node_mem[n_waddr] <= n_wdata;
    end
    n_rdata <= node_mem[n_raddr];
  end

  // sequencer registers
  spmd_state_t state, state_next;
  logic [AW-1:0]            clr_addr, clr_addr_next;
  logic [CW-1:0]            cnt, cnt_next;
  logic [CW-1:0]            round, round_next;
  logic [NW-1:0]            start_n, start_n_next;
  logic [NW-1:0]            goal_n, goal_n_next;
  logic [NODE_FIELD_BITS-1:0] start_f, start_f_next;
  logic [NW-1:0]            best, best_next;
  logic                     best_ok, best_ok_next;
  logic [DIST_BITS:0]       best_key, best_key_next;
  node_t                    best_word, best_word_next;
  logic [AW-1:0]            rel_base, rel_base_next;
  logic [NW-1:0]            cur, cur_next;
  logic [LEN_BITS-1:0]      plen, plen_next;
  logic [ROUTE_BITS-1:0]    emit_idx, emit_idx_next;
  logic [DIST_BITS-1:0]     route_dist, route_dist_next;
  logic                     route_ok, route_ok_next;
  logic [ROUTE_BITS-1:0]    path_buf [ROUTE_MAX];
  logic                     pb_we;
  logic [ROUTE_BITS-1:0]    pb_addr, pb_data;
  logic                     m_valid_next, m_last_next;
  logic [M_DATA_BITS-1:0]   m_data_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr      <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      clr_addr      <= clr_addr_next;
      m_axis_tvalid <= m_valid_next;
    end
    cnt          <= cnt_next;
    round        <= round_next;
    start_n      <= start_n_next;
    goal_n       <= goal_n_next;
    start_f      <= start_f_next;
    best         <= best_next;
    best_ok      <= best_ok_next;
    best_key     <= best_key_next;
    best_word    <= best_word_next;
    rel_base     <= rel_base_next;
    cur          <= cur_next;
    plen         <= plen_next;
    emit_idx     <= emit_idx_next;
    route_dist   <= route_dist_next;
    route_ok     <= route_ok_next;
    m_axis_tdata <= m_data_next;
    m_axis_tlast <= m_last_next;
    if (pb_we) begin
      path_buf[pb_addr] <= pb_data;
    end
  end

  always_comb begin
    logic [NW-1:0]        pidx;
    logic [DIST_BITS:0]   key;
    logic                 take;
    logic [SW-1:0]        sum;
    logic [DIST_BITS-1:0] sum_sat;
    logic                 round_end;
    logic                 out_free;

    state_next      = state;
    clr_addr_next   = clr_addr;
    cnt_next        = cnt;
    round_next      = round;
    start_n_next    = start_n;
    goal_n_next     = goal_n;
    start_f_next    = start_f;
    best_next       = best;
    best_ok_next    = best_ok;
    best_key_next   = best_key;
    best_word_next  = best_word;
    rel_base_next   = rel_base;
    cur_next        = cur;
    plen_next       = plen;
    emit_idx_next   = emit_idx;
    route_dist_next = route_dist;
    route_ok_next   = route_ok;
    pb_we           = 1'b0;
    pb_addr         = plen[ROUTE_BITS-1:0];
    pb_data         = cur[ROUTE_BITS-1:0];
    out_free        = !m_axis_tvalid || m_axis_tready;
    m_valid_next    = m_axis_tvalid && !m_axis_tready;
    m_data_next     = m_axis_tdata;
    m_last_next     = m_axis_tlast;
    s_axis_tready   = 1'b0;
    e_we            = 1'b0;
    e_waddr         = clr_addr;
    e_wdata         = '0;
    e_raddr         = (int'(cnt) < NODES) ? AW'(rel_base + AW'(cnt)) : rel_base;
    n_we            = 1'b0;
    n_waddr         = cnt[NW-1:0];
    n_wdata         = '0;
    n_raddr         = (int'(cnt) < NODES) ? cnt[NW-1:0] : '0;
    pidx            = NW'(cnt - 1'b1);
    key             = n_rdata.reached ? {1'b0, n_rdata.distance} : KEY_NONE;
    take            = 1'b0;
    sum             = SW'(n_rdata.distance) + SW'(e_rdata);
    sum_sat         = (sum > SW'(DIST_MAX)) ? DIST_MAX : sum[DIST_BITS-1:0];
    round_end       = (int'(round) == NODES - 2);

    unique case (state)
      ST_CLEAR: begin
        e_we          = 1'b1;
        clr_addr_next = AW'(clr_addr + 1'b1);
        if (clr_addr == AW'(EDGES - 1)) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (s_axis_tuser == FUNC_WRITE) begin
            if (int'(f_from) < NODES && int'(f_to) < NODES) begin
              e_we    = 1'b1;
              e_waddr = AW'(int'(f_from) * NODES + int'(f_to));
              e_wdata = weight_ext[WEIGHT_BITS-1:0];
            end
          end else begin
            start_f_next = f_start;
            start_n_next = start_ext[NW-1:0];
            goal_n_next  = goal_ext[NW-1:0];
            cnt_next     = '0;
            if (int'(f_start) < NODES && int'(f_goal) < NODES) begin
              state_next = ST_INIT;
            end else begin
              pb_we           = 1'b1;
              pb_addr         = '0;
              pb_data         = f_start;
              plen_next       = LEN_BITS'(1);
              emit_idx_next   = '0;
              route_dist_next = DIST_MAX;
              route_ok_next   = 1'b0;
              state_next      = ST_EMIT;
            end
          end
        end
      end

      ST_INIT: begin
        n_we            = 1'b1;
        n_wdata.reached = (cnt[NW-1:0] == start_n);
        cnt_next        = CW'(cnt + 1'b1);
        if (int'(cnt) == NODES - 1) begin
          cnt_next      = '0;
          round_next    = '0;
          best_ok_next  = 1'b0;
          best_key_next = KEY_NONE;
          state_next    = ST_SEL;
        end
      end

      ST_SEL: begin
        cnt_next = CW'(cnt + 1'b1);
        if (cnt != '0) begin
          take = !n_rdata.done && (key <= best_key);
          if (take) begin
            best_next      = pidx;
            best_ok_next   = 1'b1;
            best_key_next  = key;
            best_word_next = n_rdata;
          end
        end
        if (int'(cnt) == NODES) begin
          cnt_next = '0;
          if (!(best_ok || take)) begin
            cur_next   = goal_n;
            plen_next  = '0;
            state_next = ST_WALK_RD;
          end else begin
            state_next = ST_MARK;
          end
        end
      end

      ST_MARK: begin
        n_we          = 1'b1;
        n_waddr       = best;
        n_wdata       = best_word;
        n_wdata.done  = 1'b1;
        rel_base_next = AW'(int'(best) * NODES);
        cnt_next      = '0;
        if (best_word.reached) begin
          state_next = ST_RELAX;
        end else if (round_end) begin
          cur_next   = goal_n;
          plen_next  = '0;
          state_next = ST_WALK_RD;
        end else begin
          round_next    = CW'(round + 1'b1);
          best_ok_next  = 1'b0;
          best_key_next = KEY_NONE;
          state_next    = ST_SEL;
        end
      end

      ST_RELAX: begin
        cnt_next = CW'(cnt + 1'b1);
        sum      = SW'(best_word.distance) + SW'(e_rdata);
        sum_sat  = (sum > SW'(DIST_MAX)) ? DIST_MAX : sum[DIST_BITS-1:0];
        if (cnt != '0 && !n_rdata.done && e_rdata != '0) begin
          if (!n_rdata.reached || sum_sat < n_rdata.distance) begin
            n_we             = 1'b1;
            n_waddr          = pidx;
            n_wdata.reached  = 1'b1;
            n_wdata.parent   = best;
            n_wdata.distance = sum_sat;
          end
        end
        if (int'(cnt) == NODES) begin
          cnt_next = '0;
          if (round_end) begin
            cur_next   = goal_n;
            plen_next  = '0;
            state_next = ST_WALK_RD;
          end else begin
            round_next    = CW'(round + 1'b1);
            best_ok_next  = 1'b0;
            best_key_next = KEY_NONE;
            state_next    = ST_SEL;
          end
        end
      end

      ST_WALK_RD: begin
        n_raddr    = cur;
        state_next = ST_WALK;
      end

      ST_WALK: begin
        n_raddr = cur;
        if (plen == '0 && !n_rdata.reached) begin
          pb_we           = 1'b1;
          pb_addr         = '0;
          pb_data         = start_f;
          plen_next       = LEN_BITS'(1);
          emit_idx_next   = '0;
          route_dist_next = DIST_MAX;
          route_ok_next   = 1'b0;
          state_next      = ST_EMIT;
        end else begin
          if (plen == '0) begin
            route_dist_next = n_rdata.distance;
            route_ok_next   = 1'b1;
          end
          pb_we         = 1'b1;
          plen_next     = LEN_BITS'(plen + 1'b1);
          emit_idx_next = plen[ROUTE_BITS-1:0];
          if (cur == start_n || int'(plen) + 1 >= ROUTE_MAX) begin
            state_next = ST_EMIT;
          end else begin
            cur_next   = n_rdata.parent;
            state_next = ST_WALK_RD;
          end
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          m_valid_next  = 1'b1;
          m_data_next   = {route_ok, route_dist, path_buf[emit_idx]};
          m_last_next   = (emit_idx == '0);
          emit_idx_next = ROUTE_BITS'(emit_idx - 1'b1);
          if (emit_idx == '0) begin
            state_next = ST_IDLE;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/spmd_checker.sv
// ----------------------------------------------------------------------------
// spmd_checker
// Port-level checks for the shortest-path matrix block, bound to the top.
// ----------------------------------------------------------------------------
module spmd_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             s_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [spmd_pkg::M_DATA_BITS-1:0] m_axis_tdata,
  input logic                             m_axis_tlast
);

  import spmd_pkg::*;

  // stalled output transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output transaction changed while stalled");

  // unreachable goal: single transaction at saturated distance
  a_unreach: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[15] |->
      m_axis_tlast && (m_axis_tdata[14:3] == DIST_MAX))
    else $error("unreachable result malformed");

  // matrix clear keeps the input closed straight after reset
  a_clear: assert property (@(posedge clk)
    $past(rst) |-> !s_axis_tready)
    else $error("input open during clearing pass");

  // an accepted query closes the input
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == FUNC_QUERY |=>
      !s_axis_tready)
    else $error("input open during a query");

endmodule

bind shortest_path_matrix_dijkstra spmd_checker u_spmd_checker (.*);

FILE: bench/shortest_path_matrix_dijkstra_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shortest_path_matrix_dijkstra_test
// Self-checking bench for the adjacency-matrix route search. Edge writes and
// route queries go in on the input stream. A scoreboard keeps its own copy of
// the matrix and runs the search for each accepted query. Every output
// transaction is compared with the oldest expected route node. A directed
// opening covers empty-graph, longest-route, tie and edge-removal cases.
// Random graph sessions follow under changing sender and receiver throttling.
// ----------------------------------------------------------------------------
module shortest_path_matrix_dijkstra_test;
  import spmd_pkg::*;

  localparam int NODE_COUNT   = NODES_DEF;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 400;
  localparam int PHASE_ITEMS  = 91;

  typedef struct packed {
    logic [NODE_FIELD_BITS-1:0] node;
    logic [DIST_BITS-1:0]       cost;
    logic                       ok;
    logic                       fin;
  } route_step_t;

  class route_scoreboard;
    logic [WEIGHT_FIELD-1:0] weight [NODE_COUNT][NODE_COUNT];
    route_step_t             route_q[$];
    int                      mismatches;

    function new();
      foreach (weight[i, j]) weight[i][j] = '0;
      mismatches = 0;
    endfunction

    function void note_input(logic func, logic [S_DATA_BITS-1:0] data);
      if (func == FUNC_WRITE)
        weight[data[2:0]][data[5:3]] = data[13:6];
      else
        plan_route(int'(data[16:14]), int'(data[19:17]));
    endfunction

    function void plan_route(int start_n, int goal_n);
      int          node_cost [NODE_COUNT];
      int          parent [NODE_COUNT];
      bit          reached [NODE_COUNT];
      bit          visited [NODE_COUNT];
      int          best, best_key, key, sum, node;
      int          trail[$];
      route_step_t step;
      for (int i = 0; i < NODE_COUNT; i++) begin
        node_cost[i] = 0;
        parent[i]    = 0;
        reached[i]   = 1'b0;
        visited[i]   = 1'b0;
      end
      reached[start_n] = 1'b1;
      for (int r = 0; r + 1 < NODE_COUNT; r++) begin
        best     = NODE_COUNT;
        best_key = int'(DIST_MAX) + 1;
        for (int v = 0; v < NODE_COUNT; v++) begin
          if (!visited[v]) begin
            key = reached[v] ? node_cost[v] : int'(DIST_MAX) + 1;
            // ties go to the higher index
            if (key <= best_key) begin
              best_key = key;
              best     = v;
            end
          end
        end
        if (best >= NODE_COUNT) break;
        visited[best] = 1'b1;
        if (reached[best]) begin
          for (int v = 0; v < NODE_COUNT; v++) begin
            if (!visited[v] && weight[best][v] != 0) begin
              sum = node_cost[best] + int'(weight[best][v]);
              if (sum > int'(DIST_MAX)) sum = int'(DIST_MAX);
              if (!reached[v] || sum < node_cost[v]) begin
                reached[v]   = 1'b1;
                node_cost[v] = sum;
                parent[v]    = best;
              end
            end
          end
        end
      end
      if (!reached[goal_n]) begin
        step.node = NODE_FIELD_BITS'(start_n);
        step.cost = DIST_MAX;
        step.ok   = 1'b0;
        step.fin  = 1'b1;
        route_q.push_back(step);
        return;
      end
      node = goal_n;
      forever begin
        trail.push_front(node);
        if (node == start_n || trail.size() >= ROUTE_MAX) break;
        node = parent[node];
      end
      foreach (trail[k]) begin
        step.node = NODE_FIELD_BITS'(trail[k]);
        step.cost = DIST_BITS'(node_cost[goal_n]);
        step.ok   = 1'b1;
        step.fin  = (k == trail.size() - 1);
        route_q.push_back(step);
      end
    endfunction

    function void check_result(logic [M_DATA_BITS-1:0] data, logic last);
      route_step_t got, want;
      got.node = data[2:0];
      got.cost = data[14:3];
      got.ok   = data[15];
      got.fin  = last;
      if (route_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output: node %0d cost %0d ok %0b last %0b",
                   got.node, got.cost, got.ok, got.fin);
        return;
      end
      want = route_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp node %0d cost %0d ok %0b last %0b,",
                   want.node, want.cost, want.ok, want.fin,
                   " got node %0d cost %0d ok %0b last %0b",
                   got.node, got.cost, got.ok, got.fin);
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [S_DATA_BITS-1:0] s_axis_tdata = '0;
  logic                   s_axis_tuser = FUNC_WRITE;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [M_DATA_BITS-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int cycles       = 0;

  route_scoreboard sb = new();

  shortest_path_matrix_dijkstra dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tlast);
    m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  function automatic logic [S_DATA_BITS-1:0] pack_item(
    logic [2:0] from_n, logic [2:0] to_n, logic [7:0] w,
    logic [2:0] start_n, logic [2:0] goal_n);
    return {4'b0, goal_n, start_n, w, to_n, from_n};
  endfunction

  // valid stays high across back-to-back transactions
  task automatic send_item(input logic func, input logic [S_DATA_BITS-1:0] data);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= data;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_input(func, data);
  endtask

  task automatic send_edge(input logic [2:0] from_n, input logic [2:0] to_n,
                           input logic [7:0] w);
    send_item(FUNC_WRITE, pack_item(from_n, to_n, w, 3'($urandom_range(7)),
                                    3'($urandom_range(7))));
  endtask

  task automatic send_query(input logic [2:0] start_n, input logic [2:0] goal_n);
    send_item(FUNC_QUERY, pack_item(3'($urandom_range(7)), 3'($urandom_range(7)),
                                    8'($urandom_range(255)), start_n, goal_n));
  endtask

  // random graph sessions: a burst of edge writes, then a few queries
  task automatic run_phase(input int tx_pct, input int rx_pct, input int items);
    int         sent, zero_pct, writes, queries, pick;
    logic [2:0] a, b;
    logic [7:0] w;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(2);
      zero_pct = (pick == 0) ? 15 : (pick == 1) ? 45 : 75;
      writes  = $urandom_range(4, 14);
      queries = $urandom_range(1, 4);
      repeat (writes) begin
        a = 3'($urandom_range(7));
        b = ($urandom_range(9) < 3) ? a + 3'd1 : 3'($urandom_range(7));
        pick = $urandom_range(9);
        if ($urandom_range(99) < zero_pct) w = 8'd0;
        else if (pick == 0) w = 8'd1;
        else if (pick == 1) w = 8'd255;
        else if (pick < 6) w = 8'($urandom_range(1, 15));
        else w = 8'($urandom_range(1, 255));
        send_edge(a, b, w);
        sent++;
      end
      repeat (queries) begin
        send_query(3'($urandom_range(7)), 3'($urandom_range(7)));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // empty matrix after reset
    send_query(3'd0, 3'd5);
    // full-length chain
    send_edge(3'd0, 3'd1, 8'd1);
    send_edge(3'd1, 3'd2, 8'd255);
    send_edge(3'd2, 3'd3, 8'd1);
    send_edge(3'd3, 3'd4, 8'd128);
    send_edge(3'd4, 3'd5, 8'd1);
    send_edge(3'd5, 3'd6, 8'd255);
    send_edge(3'd6, 3'd7, 8'd1);
    send_query(3'd0, 3'd7);
    send_query(3'd7, 3'd0);
    send_query(3'd3, 3'd3);
    // shortcut, then equal-cost alternatives
    send_edge(3'd0, 3'd7, 8'd255);
    send_query(3'd0, 3'd7);
    send_edge(3'd2, 3'd4, 8'd129);
    send_query(3'd0, 3'd4);
    send_edge(3'd0, 3'd6, 8'd255);
    send_query(3'd0, 3'd5);
    // edge removal
    send_edge(3'd1, 3'd2, 8'd0);
    send_query(3'd0, 3'd4);
    send_query(3'd7, 3'd7);
    send_query(3'd0, 3'd0);

    run_phase(0, 0, PHASE_ITEMS);
    run_phase(69, 0, PHASE_ITEMS);
    run_phase(0, 69, PHASE_ITEMS);
    run_phase(26, 26, PHASE_ITEMS);
    s_axis_tvalid <= 1'b0;

    while (sb.route_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.route_q.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: shortest_path_matrix_dijkstra.f
rtl/spmd_pkg.sv
rtl/shortest_path_matrix_dijkstra.sv
rtl/spmd_checker.sv
bench/shortest_path_matrix_dijkstra_test.sv
